FILE: src/spc700_control_instruction_unit_defines.svh
// Assertion macros shared by the control instruction unit checkers.
`ifndef SPC700_CONTROL_INSTRUCTION_UNIT_DEFINES_SVH
`define SPC700_CONTROL_INSTRUCTION_UNIT_DEFINES_SVH

// Implication in the same cycle, masked while reset is asserted.
`define SPCCTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, masked while reset is asserted.
`define SPCCTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check what a reset cycle leaves behind.
`define SPCCTL_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

FILE: src/spcctl_pkg.sv
// Shared types and constants of the control instruction unit.
package spcctl_pkg;

    localparam logic [15:0] BOOT_PC     = 16'hFFC0;
    localparam logic [7:0]  SP_RESET    = 8'hEF;
    localparam logic [7:0]  PCALL_PAGE  = 8'hFF;

    // PSW bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_H = 3;
    localparam int FLAG_P = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Opcodes of the control group
    localparam logic [3:0] OPC_TCALL_LO = 4'h1;
    localparam logic [7:0] OPC_NOP   = 8'h00;
    localparam logic [7:0] OPC_PUSHP = 8'h0D;
    localparam logic [7:0] OPC_PUSHA = 8'h2D;
    localparam logic [7:0] OPC_PUSHX = 8'h4D;
    localparam logic [7:0] OPC_PUSHY = 8'h6D;
    localparam logic [7:0] OPC_POPP  = 8'h8E;
    localparam logic [7:0] OPC_POPX  = 8'hCE;
    localparam logic [7:0] OPC_POPY  = 8'hEE;
    localparam logic [7:0] OPC_DECX  = 8'h1D;
    localparam logic [7:0] OPC_INCX  = 8'h3D;
    localparam logic [7:0] OPC_DECY  = 8'hDC;
    localparam logic [7:0] OPC_MOVAX = 8'h7D;
    localparam logic [7:0] OPC_MOVXS = 8'h9D;
    localparam logic [7:0] OPC_ASL   = 8'h1C;
    localparam logic [7:0] OPC_ROL   = 8'h3C;
    localparam logic [7:0] OPC_LSR   = 8'h5C;
    localparam logic [7:0] OPC_ROR   = 8'h7C;
    localparam logic [7:0] OPC_CLRP  = 8'h20;
    localparam logic [7:0] OPC_CLRC  = 8'h60;
    localparam logic [7:0] OPC_SETC  = 8'h80;
    localparam logic [7:0] OPC_NOTC  = 8'hED;
    localparam logic [7:0] OPC_CLRV  = 8'hE0;
    localparam logic [7:0] OPC_DI    = 8'hC0;
    localparam logic [7:0] OPC_CALL  = 8'h3F;
    localparam logic [7:0] OPC_PCALL = 8'h4F;
    localparam logic [7:0] OPC_JMP   = 8'h5F;
    localparam logic [7:0] OPC_RET   = 8'h6F;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SIMPLE,
        KIND_PUSH,
        KIND_POP,
        KIND_CALL,
        KIND_RET
    } t_kind;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_JMP,
        OP_DECX,
        OP_INCX,
        OP_DECY,
        OP_MOVAX,
        OP_MOVXSP,
        OP_ASL,
        OP_ROL,
        OP_LSR,
        OP_ROR,
        OP_CLRP,
        OP_CLRC,
        OP_SETC,
        OP_NOTC,
        OP_CLRV,
        OP_DI
    } t_op;

    typedef enum logic [1:0] {
        REG_PSW,
        REG_A,
        REG_X,
        REG_Y
    } t_reg;

    // Decoded instruction handed from the front end to the execution side
    typedef struct packed {
        t_kind       kind;
        t_op         op;
        t_reg        sel;
        logic [15:0] target;
        logic [1:0]  len;
    } t_cmd;

endpackage

FILE: src/spcctl_front.sv
// Front end: accept instructions and decode them into commands.
module spcctl_front (
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_opcode,
    input  logic [7:0]        i_operand_low,
    input  logic [7:0]        i_operand_high,
    input  logic [15:0]       i_vector_word,
    input  logic              i_q_full,
    output logic              o_q_push,
    output spcctl_pkg::t_cmd  o_cmd
);

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.kind   = spcctl_pkg::KIND_NONE;
        o_cmd.op     = spcctl_pkg::OP_NOP;
        o_cmd.sel    = spcctl_pkg::REG_A;
        o_cmd.target = {i_operand_high, i_operand_low};
        o_cmd.len    = 2'd0;
        if (i_opcode[3:0] == spcctl_pkg::OPC_TCALL_LO) begin
            o_cmd.kind   = spcctl_pkg::KIND_CALL;
            o_cmd.target = i_vector_word;
            o_cmd.len    = 2'd1;
        end else begin
            o_cmd.len = 2'd1;
            unique case (i_opcode)
                spcctl_pkg::OPC_NOP: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                end
                spcctl_pkg::OPC_PUSHP: begin
                    o_cmd.kind = spcctl_pkg::KIND_PUSH;
                    o_cmd.sel  = spcctl_pkg::REG_PSW;
                end
                spcctl_pkg::OPC_PUSHA: begin
                    o_cmd.kind = spcctl_pkg::KIND_PUSH;
                    o_cmd.sel  = spcctl_pkg::REG_A;
                end
                spcctl_pkg::OPC_PUSHX: begin
                    o_cmd.kind = spcctl_pkg::KIND_PUSH;
                    o_cmd.sel  = spcctl_pkg::REG_X;
                end
                spcctl_pkg::OPC_PUSHY: begin
                    o_cmd.kind = spcctl_pkg::KIND_PUSH;
                    o_cmd.sel  = spcctl_pkg::REG_Y;
                end
                spcctl_pkg::OPC_POPP: begin
                    o_cmd.kind = spcctl_pkg::KIND_POP;
                    o_cmd.sel  = spcctl_pkg::REG_PSW;
                end
                spcctl_pkg::OPC_POPX: begin
                    o_cmd.kind = spcctl_pkg::KIND_POP;
                    o_cmd.sel  = spcctl_pkg::REG_X;
                end
                spcctl_pkg::OPC_POPY: begin
                    o_cmd.kind = spcctl_pkg::KIND_POP;
                    o_cmd.sel  = spcctl_pkg::REG_Y;
                end
                spcctl_pkg::OPC_DECX: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_DECX;
                end
                spcctl_pkg::OPC_INCX: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_INCX;
                end
                spcctl_pkg::OPC_DECY: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_DECY;
                end
                spcctl_pkg::OPC_MOVAX: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_MOVAX;
                end
                spcctl_pkg::OPC_MOVXS: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_MOVXSP;
                end
                spcctl_pkg::OPC_ASL: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_ASL;
                end
                spcctl_pkg::OPC_ROL: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_ROL;
                end
                spcctl_pkg::OPC_LSR: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_LSR;
                end
                spcctl_pkg::OPC_ROR: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_ROR;
                end
                spcctl_pkg::OPC_CLRP: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_CLRP;
                end
                spcctl_pkg::OPC_CLRC: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_CLRC;
                end
                spcctl_pkg::OPC_SETC: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_SETC;
                end
                spcctl_pkg::OPC_NOTC: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_NOTC;
                end
                spcctl_pkg::OPC_CLRV: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_CLRV;
                end
                spcctl_pkg::OPC_DI: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_DI;
                end
                spcctl_pkg::OPC_CALL: begin
                    o_cmd.kind = spcctl_pkg::KIND_CALL;
                    o_cmd.len  = 2'd3;
                end
                spcctl_pkg::OPC_PCALL: begin
                    o_cmd.kind   = spcctl_pkg::KIND_CALL;
                    o_cmd.target = {spcctl_pkg::PCALL_PAGE, i_operand_low};
                    o_cmd.len    = 2'd2;
                end
                spcctl_pkg::OPC_JMP: begin
                    o_cmd.kind = spcctl_pkg::KIND_SIMPLE;
                    o_cmd.op   = spcctl_pkg::OP_JMP;
                    o_cmd.len  = 2'd3;
                end
                spcctl_pkg::OPC_RET: begin
                    o_cmd.kind = spcctl_pkg::KIND_RET;
                end
                default: begin
                    // not in the group: PC stays put
                    o_cmd.len = 2'd0;
                end
            endcase
        end
    end

endmodule

FILE: src/spcctl_queue.sv
// Short command queue between the front end and the execution side.
module spcctl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spcctl_pkg::t_cmd  i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output spcctl_pkg::t_cmd  o_head
);

    spcctl_pkg::t_cmd                 r_slot [spcctl_pkg::QUEUE_DEPTH];
    logic [spcctl_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [spcctl_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [spcctl_pkg::QUEUE_AW:0]    r_count;

    assign o_full  = (r_count == (spcctl_pkg::QUEUE_AW + 1)'(spcctl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: src/spcctl_back.sv
// Execution side: CPU registers, stack page and the result register.
module spcctl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  spcctl_pkg::t_cmd  i_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_handled,
    output logic [15:0]       o_new_pc,
    output logic [7:0]        o_new_acc,
    output logic [7:0]        o_new_index_x,
    output logic [7:0]        o_new_index_y,
    output logic [7:0]        o_new_stack_ptr,
    output logic [7:0]        o_new_status
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_PUSH_LO  = 5'b00010,
        ST_POP_DATA = 5'b00100,
        ST_RET_LO   = 5'b01000,
        ST_RET_HI   = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [15:0]  r_pc, n_pc;
    logic [7:0]   r_a, n_a;
    logic [7:0]   r_x, n_x;
    logic [7:0]   r_y, n_y;
    logic [7:0]   r_sp, n_sp;
    logic [7:0]   r_psw, n_psw;
    logic [7:0]   r_lo, n_lo;
    logic         r_out_valid;

    logic [7:0]   r_mem [256];
    logic [7:0]   r_rd_data;
    logic [7:0]   mem_addr;
    logic         mem_we;
    logic [7:0]   mem_wdata;

    logic         out_free;
    logic         emit;
    logic [15:0]  ret_addr;

    function automatic logic [7:0] f_nz(input logic [7:0] psw, input logic [7:0] v);
        logic [7:0] f;
        f = psw;
        f[spcctl_pkg::FLAG_N] = v[7];
        f[spcctl_pkg::FLAG_Z] = (v == 8'd0);
        return f;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign ret_addr = r_pc + {14'd0, i_cmd.len};
    assign o_q_pop  = emit;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_a       = r_a;
        n_x       = r_x;
        n_y       = r_y;
        n_sp      = r_sp;
        n_psw     = r_psw;
        n_lo      = r_lo;
        mem_addr  = r_sp;
        mem_we    = 1'b0;
        mem_wdata = 8'd0;
        emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.kind)
                        spcctl_pkg::KIND_NONE: begin
                            emit = out_free;
                        end
                        spcctl_pkg::KIND_SIMPLE: begin
                            // hold every register until the result register is free
                            if (out_free) begin
                                emit = 1'b1;
                                n_pc = ret_addr;
                                case (i_cmd.op)
                                    spcctl_pkg::OP_JMP: n_pc = i_cmd.target;
                                    spcctl_pkg::OP_DECX: begin
                                        n_x   = r_x - 8'd1;
                                        n_psw = f_nz(r_psw, n_x);
                                    end
                                    spcctl_pkg::OP_INCX: begin
                                        n_x   = r_x + 8'd1;
                                        n_psw = f_nz(r_psw, n_x);
                                    end
                                    spcctl_pkg::OP_DECY: begin
                                        n_y   = r_y - 8'd1;
                                        n_psw = f_nz(r_psw, n_y);
                                    end
                                    spcctl_pkg::OP_MOVAX: begin
                                        n_a   = r_x;
                                        n_psw = f_nz(r_psw, n_a);
                                    end
                                    spcctl_pkg::OP_MOVXSP: begin
                                        n_x   = r_sp;
                                        n_psw = f_nz(r_psw, n_x);
                                    end
                                    spcctl_pkg::OP_ASL: begin
                                        n_a   = {r_a[6:0], 1'b0};
                                        n_psw = f_nz(r_psw, n_a);
                                        n_psw[spcctl_pkg::FLAG_C] = r_a[7];
                                    end
                                    spcctl_pkg::OP_ROL: begin
                                        n_a   = {r_a[6:0], r_psw[spcctl_pkg::FLAG_C]};
                                        n_psw = f_nz(r_psw, n_a);
                                        n_psw[spcctl_pkg::FLAG_C] = r_a[7];
                                    end
                                    spcctl_pkg::OP_LSR: begin
                                        n_a   = {1'b0, r_a[7:1]};
                                        n_psw = f_nz(r_psw, n_a);
                                        n_psw[spcctl_pkg::FLAG_C] = r_a[0];
                                    end
                                    spcctl_pkg::OP_ROR: begin
                                        n_a   = {r_psw[spcctl_pkg::FLAG_C], r_a[7:1]};
                                        n_psw = f_nz(r_psw, n_a);
                                        n_psw[spcctl_pkg::FLAG_C] = r_a[0];
                                    end
                                    spcctl_pkg::OP_CLRP: n_psw[spcctl_pkg::FLAG_P] = 1'b0;
                                    spcctl_pkg::OP_CLRC: n_psw[spcctl_pkg::FLAG_C] = 1'b0;
                                    spcctl_pkg::OP_SETC: n_psw[spcctl_pkg::FLAG_C] = 1'b1;
                                    spcctl_pkg::OP_NOTC: begin
                                        n_psw[spcctl_pkg::FLAG_C] = !r_psw[spcctl_pkg::FLAG_C];
                                    end
                                    spcctl_pkg::OP_CLRV: begin
                                        n_psw[spcctl_pkg::FLAG_H] = 1'b0;
                                        n_psw[spcctl_pkg::FLAG_V] = 1'b0;
                                    end
                                    spcctl_pkg::OP_DI: n_psw[spcctl_pkg::FLAG_I] = 1'b0;
                                    default: n_pc = ret_addr;
                                endcase
                            end
                        end
                        spcctl_pkg::KIND_PUSH: begin
                            if (out_free) begin
                                emit   = 1'b1;
                                mem_we = 1'b1;
                                case (i_cmd.sel)
                                    spcctl_pkg::REG_PSW: mem_wdata = r_psw;
                                    spcctl_pkg::REG_A:   mem_wdata = r_a;
                                    spcctl_pkg::REG_X:   mem_wdata = r_x;
                                    default:             mem_wdata = r_y;
                                endcase
                                n_sp = r_sp - 8'd1;
                                n_pc = ret_addr;
                            end
                        end
                        spcctl_pkg::KIND_POP, spcctl_pkg::KIND_RET: begin
                            mem_addr = r_sp + 8'd1;
                            n_sp     = r_sp + 8'd1;
                            n_state  = (i_cmd.kind == spcctl_pkg::KIND_POP) ?
                                       ST_POP_DATA : ST_RET_LO;
                        end
                        spcctl_pkg::KIND_CALL: begin
                            mem_we    = 1'b1;
                            mem_wdata = ret_addr[15:8];
                            n_sp      = r_sp - 8'd1;
                            n_state   = ST_PUSH_LO;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH_LO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = ret_addr[7:0];
                    n_sp      = r_sp - 8'd1;
                    n_pc      = i_cmd.target;
                    n_state   = ST_IDLE;
                end
            end
            ST_POP_DATA: begin
                // the read of the popped byte stays on r_sp while waiting
                if (out_free) begin
                    emit    = 1'b1;
                    n_pc    = ret_addr;
                    n_state = ST_IDLE;
                    case (i_cmd.sel)
                        spcctl_pkg::REG_PSW: n_psw = r_rd_data;
                        spcctl_pkg::REG_X:   n_x   = r_rd_data;
                        default:             n_y   = r_rd_data;
                    endcase
                end
            end
            ST_RET_LO: begin
                n_lo     = r_rd_data;
                mem_addr = r_sp + 8'd1;
                n_sp     = r_sp + 8'd1;
                n_state  = ST_RET_HI;
            end
            ST_RET_HI: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_pc    = {r_rd_data, r_lo};
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= spcctl_pkg::BOOT_PC;
            r_a         <= 8'd0;
            r_x         <= 8'd0;
            r_y         <= 8'd0;
            r_sp        <= spcctl_pkg::SP_RESET;
            r_psw       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_a         <= n_a;
            r_x         <= n_x;
            r_y         <= n_y;
            r_sp        <= n_sp;
            r_psw       <= n_psw;
            r_out_valid <= emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        if (emit) begin
            o_handled       <= (i_cmd.kind != spcctl_pkg::KIND_NONE);
            o_new_pc        <= n_pc;
            o_new_acc       <= n_a;
            o_new_index_x   <= n_x;
            o_new_index_y   <= n_y;
            o_new_stack_ptr <= n_sp;
            o_new_status    <= n_psw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/spc700_control_instruction_unit.sv
// Top level of the control instruction unit: front end, queue and execution side.
//
// Executes one control-group instruction of the 8-bit audio CPU per transaction
// and returns the full register set (PC, A, X, Y, SP, PSW) plus a handled flag;
// opcodes outside the group come back unchanged with handled low. The front end
// decodes each opcode as it is accepted and drops the command into a two-entry
// queue, so the input side keeps taking transactions while a result waits on a
// stalled output. The execution side owns the registers and a 256-byte stack
// page behind a single port with registered read data; that port sets the rate.
// Register moves, flag operations, shifts, jumps, single pushes and unhandled
// opcodes finish in the idle state; pops go on to a state that loads the popped
// byte, calls (TCALL, CALL, PCALL) to one that pushes the return low byte, and
// RET to states that read the low, then the high return byte. A result passes
// through the queue and the result register before it shows on the output.
// Reset loads PC with 0xFFC0 and SP with 0xEF, clears A, X, Y and PSW; stack
// contents are undefined until pushed.
module spc700_control_instruction_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_opcode,
    input  logic [7:0]   i_operand_low,
    input  logic [7:0]   i_operand_high,
    input  logic [15:0]  i_vector_word,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_handled,
    output logic [15:0]  o_new_pc,
    output logic [7:0]   o_new_acc,
    output logic [7:0]   o_new_index_x,
    output logic [7:0]   o_new_index_y,
    output logic [7:0]   o_new_stack_ptr,
    output logic [7:0]   o_new_status
);

    spcctl_pkg::t_cmd  front_cmd;
    spcctl_pkg::t_cmd  head_cmd;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    // Accept and decode.
    spcctl_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_operand_low  (i_operand_low),
        .i_operand_high (i_operand_high),
        .i_vector_word  (i_vector_word),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_cmd          (front_cmd)
    );

    // Hold decoded commands until the execution side is free.
    spcctl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Execute, update registers and stack, and present the result.
    spcctl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (head_cmd),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_handled       (o_handled),
        .o_new_pc        (o_new_pc),
        .o_new_acc       (o_new_acc),
        .o_new_index_x   (o_new_index_x),
        .o_new_index_y   (o_new_index_y),
        .o_new_stack_ptr (o_new_stack_ptr),
        .o_new_status    (o_new_status)
    );

endmodule

FILE: src/spcctl_checker.sv
// Port-level checks of the control instruction unit and their binding.
`include "spc700_control_instruction_unit_defines.svh"

module spcctl_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         o_in_stall,
    input  logic         o_out_valid,
    input  logic         i_out_stall,
    input  logic         o_handled,
    input  logic [15:0]  o_new_pc,
    input  logic [7:0]   o_new_acc,
    input  logic [7:0]   o_new_index_x,
    input  logic [7:0]   o_new_index_y,
    input  logic [7:0]   o_new_stack_ptr,
    input  logic [7:0]   o_new_status
);

    `SPCCTL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_handled) && $stable(o_new_pc) && $stable(o_new_acc) && $stable(o_new_index_x) && $stable(o_new_index_y) && $stable(o_new_stack_ptr) && $stable(o_new_status), "stalled result changed")
    `SPCCTL_ASSERT_AFTER_RESET(a_reset_clear, i_clk, i_rst_n, !o_out_valid && !o_in_stall, "reset left a result or a stall")
    `SPCCTL_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid && !o_in_stall), "input stall rose without a prior transaction")

endmodule

bind spc700_control_instruction_unit spcctl_checker u_checker (.*);
